// File: hdl/slid_pkg.sv
// ----------------------------------------------------------------------------
// slid_pkg
// Shared types and codes for the sorted list store: item and result
// layouts, command codes and result status codes.
// ----------------------------------------------------------------------------
package slid_pkg;

	// Field widths fixed by the item and result layouts
	localparam int unsigned VALUE_W       = 32;
	localparam int unsigned ENTRY_COUNT_W = 5;

	// Command codes; the fourth code is unused and ignored
	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_DELETE = 2'd1;
	localparam logic [1:0] CMD_DUMP   = 2'd2;

	// Result status codes
	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_FULL      = 2'd1;
	localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;
	localparam logic [1:0] STATUS_EMPTY     = 2'd3;

	typedef struct packed {
		logic [1:0]                cmd;
		logic signed [VALUE_W-1:0] value;
	} item_t;

	typedef struct packed {
		logic [1:0]                  status;
		logic signed [VALUE_W-1:0]   entry_value;
		logic [ENTRY_COUNT_W-1:0]    entry_count;
		logic                        last;
	} result_t;

endpackage

// File: hdl/slid_mem.sv
// ----------------------------------------------------------------------------
// slid_mem
// Entry store: one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module slid_mem #(
	parameter int unsigned DEPTH  = 16,
	parameter int unsigned ADDR_W = 4
) (
	input  logic                           clk,
	input  logic                           we,
	input  logic [ADDR_W-1:0]              waddr,
	input  logic signed [slid_pkg::VALUE_W-1:0] wdata,
	input  logic                           re,
	input  logic [ADDR_W-1:0]              raddr,
	output logic signed [slid_pkg::VALUE_W-1:0] rdata
);
	import slid_pkg::*;

	logic signed [VALUE_W-1:0] mem [DEPTH];

	// Write one entry
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read one entry, registered
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: hdl/slid_ctrl.sv
// ----------------------------------------------------------------------------
// slid_ctrl
// Sequencer for the sorted list: walks the entry store one entry a cycle,
// shifts entries up on insert and down on delete as it goes, emits dumped
// entries, and drives the registered result port.
// ----------------------------------------------------------------------------
module slid_ctrl #(
	parameter int unsigned CAPACITY = 16,
	parameter int unsigned ADDR_W   = 4,
	parameter int unsigned COUNT_W  = 5
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  slid_pkg::item_t                     item,
	output logic                                strobe,
	output slid_pkg::result_t                   result,
	output logic                                mem_we,
	output logic [ADDR_W-1:0]                   mem_waddr,
	output logic signed [slid_pkg::VALUE_W-1:0] mem_wdata,
	output logic                                mem_re,
	output logic [ADDR_W-1:0]                   mem_raddr,
	input  logic signed [slid_pkg::VALUE_W-1:0] mem_rdata
);
	import slid_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	localparam logic [COUNT_W-1:0] COUNT_FULL = COUNT_W'(CAPACITY);
	localparam logic [COUNT_W-1:0] COUNT_ONE  = COUNT_W'(1);

	logic [1:0]                state_q;
	logic [1:0]                cmd_q;
	logic signed [VALUE_W-1:0] val_q;
	logic [COUNT_W-1:0]        count_q;
	logic [COUNT_W-1:0]        rd_ptr_q;
	logic                      placed_q;
	logic                      found_q;
	logic signed [VALUE_W-1:0] carry_q;
	logic                      vld_s1;
	logic [ADDR_W-1:0]         idx_s1;
	logic                      strobe_q;
	result_t                   result_q;

	logic                      accept;
	logic                      cmd_known;
	logic                      more;
	logic                      full;
	logic [COUNT_W+ENTRY_COUNT_W-1:0] cnt_ext;
	logic [COUNT_W+ENTRY_COUNT_W-1:0] cnt_inc_ext;
	logic [COUNT_W+ENTRY_COUNT_W-1:0] cnt_dec_ext;

	assign cmd_known = (item.cmd == CMD_INSERT) || (item.cmd == CMD_DELETE) ||
	                   (item.cmd == CMD_DUMP);
	assign accept    = start && !busy && cmd_known;
	assign busy      = (state_q != ST_IDLE);
	assign more      = (rd_ptr_q < count_q);
	assign full      = (count_q == COUNT_FULL);

	// Fit the counts to the result field
	assign cnt_ext     = {{ENTRY_COUNT_W{1'b0}}, count_q};
	assign cnt_inc_ext = {{ENTRY_COUNT_W{1'b0}}, count_q + COUNT_ONE};
	assign cnt_dec_ext = {{ENTRY_COUNT_W{1'b0}}, count_q - COUNT_ONE};

	// Read the next entry of the walk
	assign mem_re    = (state_q == ST_RUN) && more;
	assign mem_raddr = rd_ptr_q[ADDR_W-1:0];

	// Write back shifted entries during the walk, and the tail at the end
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_s1;
		mem_wdata = mem_rdata;
		if ((state_q == ST_RUN) && vld_s1) begin
			case (cmd_q)
				CMD_INSERT: begin
					if (placed_q) begin
						mem_we    = 1'b1;
						mem_wdata = carry_q;
					end else if (!(mem_rdata < val_q)) begin
						mem_we    = 1'b1;
						mem_wdata = val_q;
					end
				end
				CMD_DELETE: begin
					if (found_q) begin
						mem_we    = 1'b1;
						mem_waddr = idx_s1 - ADDR_W'(1);
					end
				end
				default: begin
					mem_we = 1'b0;
				end
			endcase
		end else if ((state_q == ST_FIN) && (cmd_q == CMD_INSERT) && !full) begin
			mem_we    = 1'b1;
			mem_waddr = count_q[ADDR_W-1:0];
			mem_wdata = placed_q ? carry_q : val_q;
		end
	end

	// Sequence one item: take it, walk the entries, finish
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			vld_s1  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					vld_s1 <= 1'b0;
					if (accept) begin
						state_q <= ((item.cmd == CMD_INSERT) && full) ? ST_FIN : ST_RUN;
					end
				end
				ST_RUN: begin
					vld_s1 <= more;
					if (!more && !vld_s1) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					vld_s1  <= 1'b0;
					state_q <= ST_IDLE;
					if ((cmd_q == CMD_INSERT) && !full) begin
						count_q <= count_q + COUNT_ONE;
					end else if ((cmd_q == CMD_DELETE) && found_q) begin
						count_q <= count_q - COUNT_ONE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					vld_s1  <= 1'b0;
				end
			endcase
		end
	end

	// Hold the operand and advance the walk pointer and carried entry
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q    <= item.cmd;
			val_q    <= item.value;
			rd_ptr_q <= '0;
			placed_q <= 1'b0;
			found_q  <= 1'b0;
		end else if (state_q == ST_RUN) begin
			if (more) begin
				rd_ptr_q <= rd_ptr_q + COUNT_ONE;
				idx_s1   <= rd_ptr_q[ADDR_W-1:0];
			end
			if (vld_s1) begin
				if ((cmd_q == CMD_INSERT) && (placed_q || !(mem_rdata < val_q))) begin
					placed_q <= 1'b1;
					carry_q  <= mem_rdata;
				end
				if ((cmd_q == CMD_DELETE) && (mem_rdata == val_q)) begin
					found_q <= 1'b1;
				end
			end
		end
	end

	// Result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= ((state_q == ST_RUN) && vld_s1 && (cmd_q == CMD_DUMP)) ||
			            ((state_q == ST_FIN) &&
			             ((cmd_q != CMD_DUMP) || (count_q == '0)));
		end
	end

	// Result payload; the walk pointer has reached the count on the last entry
	always_ff @(posedge clk) begin
		if ((state_q == ST_RUN) && vld_s1) begin
			result_q.status      <= STATUS_OK;
			result_q.entry_value <= mem_rdata;
			result_q.entry_count <= cnt_ext[ENTRY_COUNT_W-1:0];
			result_q.last        <= !more;
		end else if (state_q == ST_FIN) begin
			result_q.last        <= 1'b1;
			result_q.entry_value <= val_q;
			result_q.entry_count <= cnt_ext[ENTRY_COUNT_W-1:0];
			case (cmd_q)
				CMD_INSERT: begin
					if (full) begin
						result_q.status <= STATUS_FULL;
					end else begin
						result_q.status      <= STATUS_OK;
						result_q.entry_count <= cnt_inc_ext[ENTRY_COUNT_W-1:0];
					end
				end
				CMD_DELETE: begin
					if (found_q) begin
						result_q.status      <= STATUS_OK;
						result_q.entry_count <= cnt_dec_ext[ENTRY_COUNT_W-1:0];
					end else begin
						result_q.status <= STATUS_NOT_FOUND;
					end
				end
				default: begin
					result_q.status      <= STATUS_EMPTY;
					result_q.entry_value <= '0;
				end
			endcase
		end
	end

	assign strobe = strobe_q;
	assign result = result_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_FULL)
		else $error("entry count beyond capacity");

	a_no_same_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && mem_re) |-> (mem_waddr != mem_raddr))
		else $error("read and write of the same entry in one cycle");

	a_count_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_FIN) |=> $stable(count_q))
		else $error("entry count changed outside the final step");

	a_s1_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> (state_q == ST_RUN))
		else $error("read data pending outside the walk");

	a_no_write_full: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_FIN) && full) |-> !mem_we)
		else $error("write into a full store");
`endif

endmodule

// File: hdl/sorted_list_insert_delete.sv
// ----------------------------------------------------------------------------
// sorted_list_insert_delete
// Bounded store of signed 32-bit values kept in ascending order, with
// insert, delete and in-order dump commands.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; an unused command
// code is dropped without a result and without raising busy. Results appear
// for one cycle each with strobe high and cannot be held off. The entries
// sit in a single memory with one read and one write port, and each command,
// but for an insert into a full store, walks the stored entries one per
// cycle with busy held high. The single result of an insert or delete comes
// out in the cycle in which busy falls, as does the empty result of a dump
// on an empty list. A dump of a non-empty list gives one result per entry
// while busy is still high, the last one marked.
// ----------------------------------------------------------------------------
module sorted_list_insert_delete #(
	parameter int unsigned CAPACITY = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  slid_pkg::item_t   item,
	output logic              strobe,
	output slid_pkg::result_t result
);
	import slid_pkg::*;

	localparam int unsigned ADDR_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned COUNT_W = $clog2(CAPACITY + 1);

	logic                      mem_we;
	logic [ADDR_W-1:0]         mem_waddr;
	logic signed [VALUE_W-1:0] mem_wdata;
	logic                      mem_re;
	logic [ADDR_W-1:0]         mem_raddr;
	logic signed [VALUE_W-1:0] mem_rdata;

	// Sequencer
	slid_ctrl #(
		.CAPACITY (CAPACITY),
		.ADDR_W   (ADDR_W),
		.COUNT_W  (COUNT_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.strobe    (strobe),
		.result    (result),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	// Entry store
	slid_mem #(
		.DEPTH  (CAPACITY),
		.ADDR_W (ADDR_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule

// File: bench/list_board_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// list_board_pkg
// Scoreboard for the sorted list store. It keeps its own ascending copy of
// the entries, works out the results of every accepted item and checks each
// result that the block gives against the oldest one still waiting.
// ----------------------------------------------------------------------------
package list_board_pkg;

	import slid_pkg::*;

	localparam int unsigned LIST_CAPACITY = 16;

	class list_scoreboard;

		logic signed [VALUE_W-1:0] entries [LIST_CAPACITY];
		int unsigned               count;
		result_t                   pending_results [$];
		int unsigned               errors;

		function new();
			count = 0;
			errors = 0;
			foreach (entries[k])
				entries[k] = '0;
		endfunction

		// Queue one expected result
		function void push_result(logic [1:0] status, logic signed [VALUE_W-1:0] val,
				logic is_last);
			result_t r;
			r.status      = status;
			r.entry_value = val;
			r.entry_count = count[ENTRY_COUNT_W-1:0];
			r.last        = is_last;
			pending_results.push_back(r);
		endfunction

		// Apply an accepted item to the copy of the list and queue its results
		function void note_item(item_t it);
			logic signed [VALUE_W-1:0] x;
			int unsigned               i;
			int unsigned               j;
			x = it.value;
			case (it.cmd)
				CMD_INSERT: begin
					if (count >= LIST_CAPACITY) begin
						push_result(STATUS_FULL, x, 1'b1);
					end else begin
						// land after all smaller entries, shift the rest up
						i = 0;
						while (i < count && entries[i] < x)
							i++;
						for (j = count; j > i; j--)
							entries[j] = entries[j-1];
						entries[i] = x;
						count++;
						push_result(STATUS_OK, x, 1'b1);
					end
				end
				CMD_DELETE: begin
					i = 0;
					while (i < count && entries[i] != x)
						i++;
					if (i >= count) begin
						push_result(STATUS_NOT_FOUND, x, 1'b1);
					end else begin
						// close the gap left by the first match
						for (j = i; j + 1 < count; j++)
							entries[j] = entries[j+1];
						count--;
						push_result(STATUS_OK, x, 1'b1);
					end
				end
				CMD_DUMP: begin
					if (count == 0) begin
						push_result(STATUS_EMPTY, '0, 1'b1);
					end else begin
						for (i = 0; i < count; i++)
							push_result(STATUS_OK, entries[i], i + 1 == count);
					end
				end
				default: begin
					// unused code: dropped by the block, nothing to expect
				end
			endcase
		endfunction

		// Compare a result with the oldest expectation, field by field
		function void check_result(result_t got);
			result_t want;
			if (pending_results.size() == 0) begin
				$error("result with nothing expected: status %0d value %0d count %0d last %0d",
					got.status, got.entry_value, got.entry_count, got.last);
				errors++;
				return;
			end
			want = pending_results.pop_front();
			if (got.status !== want.status) begin
				$error("status: expected %0d, actual %0d", want.status, got.status);
				errors++;
			end
			if (got.entry_value !== want.entry_value) begin
				$error("entry_value: expected %0d, actual %0d",
					want.entry_value, got.entry_value);
				errors++;
			end
			if (got.entry_count !== want.entry_count) begin
				$error("entry_count: expected %0d, actual %0d",
					want.entry_count, got.entry_count);
				errors++;
			end
			if (got.last !== want.last) begin
				$error("last: expected %0d, actual %0d", want.last, got.last);
				errors++;
			end
		endfunction

	endclass

endpackage

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Bench for the sorted list store. A directed run covers the empty, full and
// not-found cases, the value extremes and the unused command; a random run
// then grows and shrinks the list, often with stored operands. Every result
// is checked by the scoreboard as it leaves the block.
// ----------------------------------------------------------------------------
module tb_top;

	import slid_pkg::*;
	import list_board_pkg::*;

	localparam logic [1:0] CMD_UNUSED    = 2'd3;
	localparam int unsigned RANDOM_ITEMS = 450;
	localparam int unsigned DRAIN_CYCLES = LIST_CAPACITY + 24;

	logic    clk;
	logic    arst_n;
	logic    start;
	logic    busy;
	item_t   item;
	logic    strobe;
	result_t result;

	list_scoreboard sb;

	sorted_list_insert_delete #(
		.CAPACITY(LIST_CAPACITY)
	) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.strobe (strobe),
		.result (result)
	);

	// Free-running clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Give up on a hung run
	initial begin
		#2ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Check each result in the cycle it is strobed
	always @(posedge clk) begin
		if (arst_n && strobe)
			sb.check_result(result);
	end

	// Offer one item from a falling edge and hold it until taken
	task automatic send_item(input logic [1:0] cmd, input logic signed [VALUE_W-1:0] value);
		item_t it;
		it.cmd   = cmd;
		it.value = value;
		start <= 1'b1;
		item  <= it;
		do
			@(posedge clk);
		while (busy);
		sb.note_item(it);
		@(negedge clk);
	endtask

	// Drop start and scramble the payload for a number of cycles
	task automatic idle_for(input int unsigned cycles);
		if (cycles > 0) begin
			start <= 1'b0;
			item  <= item_t'({$urandom(), $urandom()});
			repeat (cycles) @(negedge clk);
		end
	endtask

	// Mostly short gaps, now and then a long one
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Operand: often a stored value, else a small value, an extreme or anything
	function automatic logic signed [VALUE_W-1:0] pick_value();
		int unsigned r;
		logic signed [VALUE_W-1:0] extremes [6];
		extremes = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sh0, -32'sh1,
			32'sh8000_0001, 32'sh7fff_fffe};
		r = $urandom_range(0, 99);
		if (r < 35 && sb.count > 0)
			return sb.entries[$urandom_range(0, sb.count - 1)];
		else if (r < 65)
			return $signed($urandom_range(0, 16)) - 8;
		else if (r < 78)
			return extremes[$urandom_range(0, 5)];
		return $urandom();
	endfunction

	initial begin
		int unsigned n;
		int unsigned r;
		int unsigned grow_pct;
		int unsigned shrink_pct;
		bit          no_gaps;
		logic [1:0]  cmd;

		sb     = new();
		arst_n = 1'b0;
		start  = 1'b0;
		item   = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: empty list, extremes, equal values, not found, full store
		send_item(CMD_DUMP, 32'sh1234_5678);
		send_item(CMD_DELETE, 32'sh7);
		send_item(CMD_INSERT, 32'sh7fff_ffff);
		send_item(CMD_INSERT, 32'sh8000_0000);
		send_item(CMD_INSERT, 32'sh0);
		idle_for(2);
		send_item(CMD_INSERT, -32'sh1);
		send_item(CMD_INSERT, 32'sh1);
		send_item(CMD_INSERT, 32'sh0);
		send_item(CMD_DUMP, -32'sh1);
		send_item(CMD_DELETE, 32'sh5);
		send_item(CMD_DELETE, 32'sh0);
		send_item(CMD_UNUSED, 32'sh0);
		for (n = 0; n < 11; n++)
			send_item(CMD_INSERT, $signed($urandom_range(0, 40)) - 20);
		send_item(CMD_INSERT, 32'sh3);
		send_item(CMD_DUMP, 32'sh0);
		idle_for(5);

		// Random: phases that lean towards growing, shrinking or neither
		n = 0;
		while (n < RANDOM_ITEMS) begin
			if (n % 30 == 0) begin
				r = $urandom_range(0, 2);
				grow_pct   = (r == 0) ? 70 : (r == 1) ? 25 : 45;
				shrink_pct = (r == 0) ? 15 : (r == 1) ? 60 : 40;
				no_gaps    = ($urandom_range(0, 3) == 0);
			end
			r = $urandom_range(0, 99);
			if (r < 3)
				cmd = CMD_UNUSED;
			else if (r < 3 + grow_pct)
				cmd = CMD_INSERT;
			else if (r < 3 + grow_pct + shrink_pct)
				cmd = CMD_DELETE;
			else
				cmd = CMD_DUMP;
			send_item(cmd, (cmd == CMD_DUMP) ? $signed($urandom()) : pick_value());
			if (cmd != CMD_UNUSED)
				n++;
			if (!no_gaps)
				idle_for(pick_gap());
		end
		start <= 1'b0;

		// Drain: wait for the last result, then let the block settle
		while (sb.pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.errors == 0 && sb.pending_results.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
